// ===== rtl/core/calendar_date_compare_and_difference_core_macros.svh =====
// Assertion macros shared by the date compare core.
// No dependencies; included by modules that carry assertions.
`ifndef CALENDAR_DATE_COMPARE_AND_DIFFERENCE_CORE_MACROS_SVH
`define CALENDAR_DATE_COMPARE_AND_DIFFERENCE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/cdcd_pkg.sv =====
// Types, tables and date arithmetic functions for the date compare core.
// No dependencies.
package cdcd_pkg;

    localparam int unsigned BASE_YEAR = 2000;
    localparam int unsigned MAX_YEAR  = 4095;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DNUM_W  = 21;

    // Reciprocal of 25 as 1311 / 2**15, exact for quotients of 10-bit values
    localparam int unsigned RECIP25_MUL   = 1311;
    localparam int unsigned RECIP25_SHIFT = 15;

    localparam logic [4:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Days before the first of each month in a common year
    localparam logic [8:0] MONTH_START [13] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  a_year;
        logic [MONTH_W-1:0] a_month;
        logic [DAY_W-1:0]   a_day;
        logic [YEAR_W-1:0]  b_year;
        logic [MONTH_W-1:0] b_month;
        logic [DAY_W-1:0]   b_day;
    } t_in;

    typedef struct packed {
        logic signed [DNUM_W-1:0] days_apart;
        logic                     earlier;
        logic                     same;
    } t_out;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
    } t_date;

    // floor(q / 25) for q < 1024
    function automatic logic [5:0] div25(input logic [9:0] q);
        logic [20:0] prod;
        prod = 21'(q) * 21'(RECIP25_MUL);
        return 6'(prod >> RECIP25_SHIFT);
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [9:0] q;
        logic [5:0] c;
        logic [9:0] rem;
        logic       by4;
        logic       by100;
        q     = y[YEAR_W-1:2];
        c     = div25(q);
        rem   = q - (10'(c) * 10'd25);
        by4   = (y[1:0] == 2'd0);
        by100 = by4 && (rem == 10'd0);
        return by4 && (!by100 || (c[1:0] == 2'd0));
    endfunction

    function automatic t_date norm_date(input logic [YEAR_W-1:0]  y,
                                        input logic [MONTH_W-1:0] m,
                                        input logic [DAY_W-1:0]   d);
        t_date      r;
        logic [4:0] lim;
        r.year = y;
        if (32'(y) < BASE_YEAR) begin
            r.year = YEAR_W'(BASE_YEAR);
        end
        if (32'(r.year) > MAX_YEAR) begin
            r.year = YEAR_W'(MAX_YEAR);
        end
        r.leap  = is_leap(r.year);
        r.month = m;
        if (m == 4'd0 || m > 4'd12) begin
            r.month = 4'd1;
        end
        lim = (r.month == 4'd2 && r.leap) ? 5'd29 : MONTH_LEN[r.month];
        r.day = d;
        if (d == 5'd0 || d > lim) begin
            r.day = 5'd1;
        end
        return r;
    endfunction

    // Days from year 0 (a leap year) through the given normalized date
    function automatic logic [DNUM_W-1:0] day_number(input t_date dt);
        logic [YEAR_W-1:0] p;
        logic [9:0]        q;
        logic [5:0]        c;
        logic [10:0]       leaps;
        p     = dt.year - YEAR_W'(1);
        q     = p[YEAR_W-1:2];
        c     = div25(q);
        leaps = 11'(q) - 11'(c) + 11'(c[5:2]) + 11'd1;
        return DNUM_W'(dt.year) * DNUM_W'(365)
             + DNUM_W'(leaps)
             + DNUM_W'(MONTH_START[dt.month])
             + DNUM_W'(dt.leap && (dt.month > 4'd2))
             + DNUM_W'(dt.day);
    endfunction

endpackage

// ===== rtl/core/calendar_date_compare_and_difference_core.sv =====
// Calendar date compare and difference core: top level.
// Depends on cdcd_pkg and calendar_date_compare_and_difference_core_macros.svh.
//
// Takes a pair of raw dates (A, B) per transfer and returns one result per pair:
// the signed day difference A minus B and flags for "A earlier than B" and
// "A same as B", both on the normalized dates. Normalization: years below 2000
// become 2000 (and saturate at MAX_YEAR), months outside 1..12 become 1, days
// outside the month become 1, with a 29-day February in Gregorian leap years.
// An input transfer loads the input register; the result register loads from it
// when it is empty or the output side is not stalling. A new pair can be taken
// each cycle the input is not stalled. The block is an input register followed
// by a result register; the day counts are closed-form (a constant multiply by
// 365 plus a reciprocal multiply for the century corrections), all in the one
// logic cone between them. Both channels use valid/stall; the input stall rises
// only when both registers are full and the output side is stalling. No reset
// sequence is needed beyond the synchronous reset clearing the valid bits.

`include "calendar_date_compare_and_difference_core_macros.svh"

module calendar_date_compare_and_difference_core
    import cdcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,

    // Date pair input channel
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,

    // Result output channel
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // Input register stage
    logic r_s1_valid;
    logic n_s1_valid;
    t_in  r_s1_data;

    // Result register stage
    logic r_out_valid;
    logic n_out_valid;
    t_out r_out_data;
    t_out n_out_data;

    // Stage enables: a stage loads when it is empty or its content moves on
    logic w_out_en;
    logic w_s1_en;

    // Normalized dates and their day numbers
    t_date             w_date_a;
    t_date             w_date_b;
    logic [DNUM_W-1:0] w_dnum_a;
    logic [DNUM_W-1:0] w_dnum_b;

    always_comb begin
        w_out_en   = !r_out_valid || !i_out_stall;
        w_s1_en    = !r_s1_valid || w_out_en;
        o_in_stall = !w_s1_en;

        n_s1_valid  = w_s1_en  ? i_in_valid : r_s1_valid;
        n_out_valid = w_out_en ? r_s1_valid : r_out_valid;
    end

    // Date arithmetic between the two registers
    always_comb begin
        w_date_a = norm_date(r_s1_data.a_year, r_s1_data.a_month, r_s1_data.a_day);
        w_date_b = norm_date(r_s1_data.b_year, r_s1_data.b_month, r_s1_data.b_day);
        w_dnum_a = day_number(w_date_a);
        w_dnum_b = day_number(w_date_b);

        // Difference wraps to 21 bits; flags come from the dates themselves
        n_out_data.days_apart = signed'(w_dnum_a - w_dnum_b);
        n_out_data.same       = ({w_date_a.year, w_date_a.month, w_date_a.day} ==
                                 {w_date_b.year, w_date_b.month, w_date_b.day});
        n_out_data.earlier    = ({w_date_a.year, w_date_a.month, w_date_a.day} <
                                 {w_date_b.year, w_date_b.month, w_date_b.day});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load only on a transfer into the stage
    always_ff @(posedge i_clk) begin
        if (w_s1_en && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (w_out_en && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A pair in the input stage never gets dropped: it reaches the result stage
    `ASSERT_NEXT(a_s1_advance, i_clk, i_rst_n, r_s1_valid && w_out_en, r_out_valid)
    // Equal dates give a zero difference and are never earlier
    `ASSERT_IMPLY(a_same_zero, i_clk, i_rst_n, o_out_valid && o_out_data.same, (o_out_data.days_apart == '0) && !o_out_data.earlier)
    // Earlier dates give a negative difference
    `ASSERT_IMPLY(a_earlier_neg, i_clk, i_rst_n, o_out_valid && o_out_data.earlier, o_out_data.days_apart < 0)
    // Later dates give a positive difference
    `ASSERT_IMPLY(a_later_pos, i_clk, i_rst_n, o_out_valid && !o_out_data.earlier && !o_out_data.same, o_out_data.days_apart > 0)

endmodule
